[hw/rtl/sbrd_pkg.sv]
// Shared types and constants of the sample rate and bit depth reducer.
package sbrd_pkg;

  // Fixed point: weights and the rate step are Q1.24, the depth step Q0.24
  localparam int FRAC_W     = 24;
  localparam int Q_ONE      = 1 << FRAC_W;
  localparam int ROUND_HALF = 1 << (FRAC_W - 1);

  // Register field widths
  localparam int WEIGHT_W   = FRAC_W + 1;
  localparam int DEPTH_W    = 23;
  localparam int PHASE_W    = 26;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = WEIGHT_W;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_STEP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOFTEN     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_STEP = 2'd2;

  // One-pole smoothing s' = (999 s + t) / 1000
  localparam int SMOOTH_KEEP = 999;
  localparam int SMOOTH_DIV  = 1000;

  // Quantiser threshold 0.0005 as a ratio
  localparam int THRESH_NUM = 5;
  localparam int THRESH_DEN = 10000;

  // Divider: divisor width and quotient bits retired per cycle
  localparam int DIV_W         = FRAC_W;
  localparam int DIV_STEP_BITS = 3;

  // Datapath operations issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SM_MUL,
    OP_SM_START,
    OP_SM_TAKE,
    OP_PHASE,
    OP_INT_A,
    OP_INT_B,
    OP_INT_C,
    OP_BL_A,
    OP_BL_B,
    OP_BL_C,
    OP_Q_START,
    OP_QM_A,
    OP_QM_B,
    OP_QM_C,
    OP_COMMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   depth_pass;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic reload;
    logic quant_en;
  } dp_status_t;

endpackage

[hw/rtl/sbrd_ifs.sv]
// Handshake interfaces: input samples, crushed samples and register writes.
interface sbrd_sample_if #(
  parameter int SAMPLE_WIDTH = 24
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] in_sample;

  modport source (output valid, output in_sample, input ready);
  modport sink   (input valid, input in_sample, output ready);
endinterface

interface sbrd_crushed_if #(
  parameter int SAMPLE_WIDTH = 24
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] out_sample;

  modport source (output valid, output out_sample, input ready);
  modport sink   (input valid, input out_sample, output ready);
endinterface

interface sbrd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [sbrd_pkg::CFG_IDX_W-1:0]   index;
  logic [sbrd_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/sample_rate_and_bit_depth_reducer_core.sv]
// Top level: register block, controller and datapath of the sample rate and bit depth reducer.
// The time from acceptance to the result register depends on whether a reload and quantising
// take place, and on the shared divider.
// A new word is taken only once the last one is through; a finished word waits in the output register.
// Reset (rst, synchronous): state and phase cleared, rate_step and soften one, depth_step zero.
module sample_rate_and_bit_depth_reducer_core #(
  parameter int SAMPLE_WIDTH     = 24,
  parameter int SMOOTH_FRAC_BITS = 32
) (
  input  logic           clk,
  input  logic           rst,
  sbrd_sample_if.sink    sample,
  sbrd_crushed_if.source crushed,
  sbrd_cfg_if.sink       cfg
);

  logic [sbrd_pkg::WEIGHT_W-1:0] rate_step;
  logic [sbrd_pkg::WEIGHT_W-1:0] soften;
  logic [sbrd_pkg::DEPTH_W-1:0]  depth_step;

  sbrd_pkg::dp_cmd_t             cmd;
  sbrd_pkg::dp_status_t          status;
  logic signed [SAMPLE_WIDTH-1:0] out_sample;

  // Register writes are always taken
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_step  <= sbrd_pkg::WEIGHT_W'(sbrd_pkg::Q_ONE);
      soften     <= sbrd_pkg::WEIGHT_W'(sbrd_pkg::Q_ONE);
      depth_step <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        sbrd_pkg::CFG_RATE_STEP:  rate_step  <= cfg.data[sbrd_pkg::WEIGHT_W-1:0];
        sbrd_pkg::CFG_SOFTEN:     soften     <= cfg.data[sbrd_pkg::WEIGHT_W-1:0];
        sbrd_pkg::CFG_DEPTH_STEP: depth_step <= cfg.data[sbrd_pkg::DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  sbrd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (crushed.valid),
    .out_ready (crushed.ready),
    .cmd       (cmd),
    .status    (status)
  );

  sbrd_dp #(
    .SAMPLE_WIDTH     (SAMPLE_WIDTH),
    .SMOOTH_FRAC_BITS (SMOOTH_FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .rate_step  (rate_step),
    .soften     (soften),
    .depth_step (depth_step),
    .in_sample  (sample.in_sample),
    .out_sample (out_sample)
  );

  assign crushed.out_sample = out_sample;

endmodule

[hw/rtl/sbrd_div.sv]
// Restoring unsigned divider, DIV_STEP_BITS quotient bits per cycle.
module sbrd_div #(
  parameter int DW  = 43,
  parameter int DVW = 24
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [DW-1:0]  dividend,
  input  logic [DVW-1:0] divisor,
  output logic           busy,
  output logic [DW-1:0]  quotient
);

  localparam int STEPS = sbrd_pkg::DIV_STEP_BITS;
  localparam int NCYC  = (DW + STEPS - 1) / STEPS;
  localparam int PADW  = NCYC * STEPS;
  localparam int CW    = $clog2(NCYC + 1);

  logic [PADW-1:0] num;
  logic [DVW-1:0]  rem;
  logic [DVW-1:0]  dsr;
  logic [CW-1:0]   cnt;
  logic [PADW-1:0] num_next;
  logic [DVW-1:0]  rem_next;

  // STEPS compare-subtract steps per cycle
  always_comb begin
    logic [DVW:0] t;
    num_next = num;
    rem_next = rem;
    for (int j = 0; j < STEPS; j++) begin
      t = {rem_next, num_next[PADW-1]};
      if (t >= {1'b0, dsr}) begin
        rem_next = DVW'(t - {1'b0, dsr});
        num_next = {num_next[PADW-2:0], 1'b1};
      end else begin
        rem_next = t[DVW-1:0];
        num_next = {num_next[PADW-2:0], 1'b0};
      end
    end
  end

  // Control: busy flag and iteration count
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(NCYC);
    end else if (busy) begin
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Working registers: dividend shifts out as quotient shifts in
  always_ff @(posedge clk) begin
    if (start) begin
      num <= PADW'(dividend);
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      num <= num_next;
      rem <= rem_next;
    end
  end

  assign quotient = num[DW-1:0];

endmodule

[hw/rtl/sbrd_dp.sv]
// Datapath: smoothing, hold phase, interpolation, blend and quantiser.
module sbrd_dp #(
  parameter int SAMPLE_WIDTH     = 24,
  parameter int SMOOTH_FRAC_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  sbrd_pkg::dp_cmd_t                   cmd,
  output sbrd_pkg::dp_status_t                status,
  input  logic [sbrd_pkg::WEIGHT_W-1:0]       rate_step,
  input  logic [sbrd_pkg::WEIGHT_W-1:0]       soften,
  input  logic [sbrd_pkg::DEPTH_W-1:0]        depth_step,
  input  logic signed [SAMPLE_WIDTH-1:0]      in_sample,
  output logic signed [SAMPLE_WIDTH-1:0]      out_sample
);

  localparam int SW    = SAMPLE_WIDTH;
  localparam int EXTRA = SMOOTH_FRAC_BITS - sbrd_pkg::FRAC_W;
  localparam int SMW   = SMOOTH_FRAC_BITS + 1;
  localparam int MAGW  = (SW > sbrd_pkg::WEIGHT_W) ? SW : sbrd_pkg::WEIGHT_W;
  localparam int MA    = MAGW + 2;
  localparam int MB    = sbrd_pkg::WEIGHT_W;
  localparam int PW    = MA + MB + 1;
  localparam int SUMW  = PW + 1;
  localparam int YW    = MA;
  localparam int DW    = (SMW + 10 > MAGW + 1) ? SMW + 10 : MAGW + 1;
  localparam int PHW   = sbrd_pkg::PHASE_W;
  localparam int DVW   = sbrd_pkg::DIV_W;

  localparam logic [63:0] THRESH64 = ((64'd1 << SMOOTH_FRAC_BITS) *
                                      64'(sbrd_pkg::THRESH_NUM)) /
                                     64'(sbrd_pkg::THRESH_DEN);
  localparam logic [SMW-1:0]       THRESH = THRESH64[SMW-1:0];
  localparam logic [MB-1:0]        ONE_W  = MB'(sbrd_pkg::Q_ONE);
  localparam logic [PHW:0]         ONE_P  = (PHW + 1)'(sbrd_pkg::Q_ONE);
  localparam logic signed [YW-1:0] SAT_HI = YW'((64'sd1 <<< (SW - 1)) - 64'sd1);
  localparam logic signed [YW-1:0] SAT_LO = -SAT_HI - YW'(1);

  // Model state
  logic [SMW-1:0]        rate_s;
  logic [SMW-1:0]        depth_s;
  logic [PHW-1:0]        phase;
  logic signed [SW-1:0]  held;
  logic signed [SW-1:0]  prev;

  // Working registers
  logic signed [SW-1:0]  x_r;
  logic [PHW:0]          phase_work;
  logic [DW-1:0]         sm_prod;
  logic signed [PW-1:0]  prod_r;
  logic signed [PW-1:0]  acc_r;
  logic signed [YW-1:0]  y;
  logic                  neg;
  logic signed [SW-1:0]  out_r;

  logic [MB-1:0]         rt_c;
  logic [MB-1:0]         sw_c;
  logic [SMW-1:0]        sm_src;
  logic [SMW-1:0]        sm_tgt;
  logic [MB-1:0]         inc;
  logic [PHW:0]          phase_sum;
  logic                  reload;
  logic [MB-1:0]         p;
  logic [MB-1:0]         stp;
  logic                  quant_en;
  logic signed [YW-1:0]  y_abs;
  logic [SW-1:0]         mag;
  logic                  div_start;
  logic [DW-1:0]         div_dividend;
  logic [DVW-1:0]        div_divisor;
  logic                  div_busy;
  logic [DW-1:0]         q_div;
  logic signed [MA-1:0]  mul_a;
  logic [MB-1:0]         mul_b;
  logic signed [PW-1:0]  mul_p;
  logic signed [SUMW-1:0] sum_v;
  logic signed [SUMW-1:0] rnd;
  logic signed [SW-1:0]  sat_y;

  // Weights above one act as one
  assign rt_c = (rate_step > ONE_W) ? ONE_W : rate_step;
  assign sw_c = (soften > ONE_W) ? ONE_W : soften;

  // Smoothing operands
  assign sm_src = cmd.depth_pass ? depth_s : rate_s;
  assign sm_tgt = cmd.depth_pass ? (SMW'(depth_step) << EXTRA) : (SMW'(rt_c) << EXTRA);

  // Hold phase advance; reload only when strictly past one
  assign inc       = rate_s[SMW-1:EXTRA];
  assign phase_sum = {1'b0, phase} + (PHW + 1)'(inc);
  assign reload    = phase_sum > ONE_P;
  assign p         = phase_work[MB-1:0];

  // Quantiser enable and magnitude
  assign stp      = depth_s[SMW-1:EXTRA];
  assign quant_en = (depth_s > THRESH) && (stp != '0) && (stp < ONE_W) && (y != '0);
  assign y_abs    = y[YW-1] ? -y : y;
  assign mag      = y_abs[SW-1:0];

  // Shared divider: by 1000 for smoothing, by the step for quantising
  assign div_start = (cmd.op == sbrd_pkg::OP_SM_START) || (cmd.op == sbrd_pkg::OP_Q_START);
  assign div_dividend = (cmd.op == sbrd_pkg::OP_SM_START) ?
                        (sm_prod + DW'(sm_tgt)) :
                        (DW'(mag) + DW'(stp) - DW'(1));
  assign div_divisor = (cmd.op == sbrd_pkg::OP_SM_START) ?
                       DVW'(sbrd_pkg::SMOOTH_DIV) : stp[DVW-1:0];

  sbrd_div #(
    .DW  (DW),
    .DVW (DVW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (q_div)
  );

  // Shared multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      sbrd_pkg::OP_INT_A: begin
        mul_a = MA'(prev);
        mul_b = p;
      end
      sbrd_pkg::OP_INT_B: begin
        mul_a = MA'(x_r);
        mul_b = ONE_W - p;
      end
      sbrd_pkg::OP_BL_A: begin
        mul_a = y;
        mul_b = ONE_W - sw_c;
      end
      sbrd_pkg::OP_BL_B: begin
        mul_a = MA'(held);
        mul_b = sw_c;
      end
      sbrd_pkg::OP_QM_A: begin
        mul_a = $signed(MA'(q_div[MAGW-1:0]));
        mul_b = stp;
      end
      sbrd_pkg::OP_QM_B: begin
        mul_a = $signed(prod_r[MA-1:0]);
        mul_b = ONE_W - stp;
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * $signed({1'b0, mul_b});

  // Round to nearest, halves up, then drop the fraction
  assign sum_v = SUMW'(acc_r) + SUMW'(prod_r);
  assign rnd   = (sum_v + SUMW'(sbrd_pkg::ROUND_HALF)) >>> sbrd_pkg::FRAC_W;

  // Output saturation
  assign sat_y = (y > SAT_HI) ? SAT_HI[SW-1:0] :
                 (y < SAT_LO) ? SAT_LO[SW-1:0] : y[SW-1:0];

  // Model state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      rate_s  <= '0;
      depth_s <= '0;
      phase   <= '0;
      held    <= '0;
      prev    <= '0;
    end else begin
      unique case (cmd.op)
        sbrd_pkg::OP_SM_TAKE: begin
          if (cmd.depth_pass) begin
            depth_s <= q_div[SMW-1:0];
          end else begin
            rate_s <= q_div[SMW-1:0];
          end
        end
        sbrd_pkg::OP_INT_C: held <= rnd[SW-1:0];
        sbrd_pkg::OP_COMMIT: begin
          prev  <= x_r;
          phase <= phase_work[PHW-1:0];
        end
        default: ;
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      sbrd_pkg::OP_LOAD:   x_r <= in_sample;
      sbrd_pkg::OP_SM_MUL: sm_prod <= DW'(sm_src) * DW'(sbrd_pkg::SMOOTH_KEEP);
      sbrd_pkg::OP_PHASE: begin
        phase_work <= reload ? (phase_sum - ONE_P) : phase_sum;
        y          <= YW'(held);
      end
      sbrd_pkg::OP_INT_A:  prod_r <= mul_p;
      sbrd_pkg::OP_INT_B: begin
        acc_r  <= prod_r;
        prod_r <= mul_p;
      end
      sbrd_pkg::OP_BL_A:   prod_r <= mul_p;
      sbrd_pkg::OP_BL_B: begin
        acc_r  <= prod_r;
        prod_r <= mul_p;
      end
      sbrd_pkg::OP_BL_C:   y <= rnd[YW-1:0];
      sbrd_pkg::OP_Q_START: neg <= y[YW-1];
      sbrd_pkg::OP_QM_A: begin
        acc_r  <= '0;
        prod_r <= mul_p;
      end
      sbrd_pkg::OP_QM_B:   prod_r <= mul_p;
      sbrd_pkg::OP_QM_C:   y <= neg ? -$signed(rnd[YW-1:0]) : $signed(rnd[YW-1:0]);
      sbrd_pkg::OP_COMMIT: out_r <= sat_y;
      default: ;
    endcase
  end

  assign out_sample      = out_r;
  assign status.div_busy = div_busy;
  assign status.reload   = reload;
  assign status.quant_en = quant_en;

  // The phase never rests above one
  a_phase_bound: assert property (@(posedge clk) disable iff (rst)
    phase <= PHW'(sbrd_pkg::Q_ONE))
    else $error("hold phase above one");

  // The divider is only started when idle
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

endmodule

[hw/rtl/sbrd_ctrl.sv]
// Controller: sequences the datapath through one sample and owns the output handshake.
module sbrd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sbrd_pkg::dp_cmd_t    cmd,
  input  sbrd_pkg::dp_status_t status
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_SM_MUL,
    S_SM_SUM,
    S_SM_WAIT,
    S_PHASE,
    S_INT_A,
    S_INT_B,
    S_INT_C,
    S_BL_A,
    S_BL_B,
    S_BL_C,
    S_QCHK,
    S_QWAIT,
    S_QM_A,
    S_QM_B,
    S_QM_C,
    S_FIN
  } state_t;

  state_t state;
  logic   depth_pass;
  logic   in_fire;
  logic   out_free;
  logic   commit;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign commit   = (state == S_FIN) && out_free;

  // Command decode
  always_comb begin
    cmd.op         = sbrd_pkg::OP_NONE;
    cmd.depth_pass = depth_pass;
    unique case (state)
      S_IDLE:    if (in_fire) cmd.op = sbrd_pkg::OP_LOAD;
      S_SM_MUL:  cmd.op = sbrd_pkg::OP_SM_MUL;
      S_SM_SUM:  cmd.op = sbrd_pkg::OP_SM_START;
      S_SM_WAIT: if (!status.div_busy) cmd.op = sbrd_pkg::OP_SM_TAKE;
      S_PHASE:   cmd.op = sbrd_pkg::OP_PHASE;
      S_INT_A:   cmd.op = sbrd_pkg::OP_INT_A;
      S_INT_B:   cmd.op = sbrd_pkg::OP_INT_B;
      S_INT_C:   cmd.op = sbrd_pkg::OP_INT_C;
      S_BL_A:    cmd.op = sbrd_pkg::OP_BL_A;
      S_BL_B:    cmd.op = sbrd_pkg::OP_BL_B;
      S_BL_C:    cmd.op = sbrd_pkg::OP_BL_C;
      S_QCHK:    if (status.quant_en) cmd.op = sbrd_pkg::OP_Q_START;
      S_QWAIT:   cmd.op = sbrd_pkg::OP_NONE;
      S_QM_A:    cmd.op = sbrd_pkg::OP_QM_A;
      S_QM_B:    cmd.op = sbrd_pkg::OP_QM_B;
      S_QM_C:    cmd.op = sbrd_pkg::OP_QM_C;
      S_FIN:     if (out_free) cmd.op = sbrd_pkg::OP_COMMIT;
    endcase
  end

  // State, smoothing pass and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      depth_pass <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            depth_pass <= 1'b0;
            state      <= S_SM_MUL;
          end
        end
        S_SM_MUL:  state <= S_SM_SUM;
        S_SM_SUM:  state <= S_SM_WAIT;
        S_SM_WAIT: begin
          if (!status.div_busy) begin
            if (depth_pass) begin
              state <= S_PHASE;
            end else begin
              depth_pass <= 1'b1;
              state      <= S_SM_MUL;
            end
          end
        end
        S_PHASE:   state <= status.reload ? S_INT_A : S_QCHK;
        S_INT_A:   state <= S_INT_B;
        S_INT_B:   state <= S_INT_C;
        S_INT_C:   state <= S_BL_A;
        S_BL_A:    state <= S_BL_B;
        S_BL_B:    state <= S_BL_C;
        S_BL_C:    state <= S_QCHK;
        S_QCHK:    state <= status.quant_en ? S_QWAIT : S_FIN;
        S_QWAIT:   if (!status.div_busy) state <= S_QM_A;
        S_QM_A:    state <= S_QM_B;
        S_QM_B:    state <= S_QM_C;
        S_QM_C:    state <= S_FIN;
        S_FIN:     if (out_free) state <= S_IDLE;
      endcase
    end
  end

  // A committed word is offered on the next cycle
  a_commit_valid: assert property (@(posedge clk) disable iff (rst)
    commit |=> out_valid)
    else $error("committed word not offered");

  // A blocked result keeps the controller waiting with its word intact
  a_fin_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) && !out_free |=> (state == S_FIN) && out_valid)
    else $error("result overwritten while output full");

  // No new word is taken while one is in flight
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready)
    else $error("second word accepted during processing");

endmodule

[sim/sample_rate_and_bit_depth_reducer_core_tb.sv]
// Testbench of the sample rate and bit depth reducer: directed words, then random phases.
`timescale 1ns / 1ps

module sample_rate_and_bit_depth_reducer_core_tb;
  import sbrd_pkg::*;

  localparam longint ONE_Q     = 64'sd16777216;
  localparam longint S_MAX     = 64'sd8388607;
  localparam longint S_MIN     = -64'sd8388608;
  localparam longint DEPTH_MIN = ((64'sd1 <<< 32) * 5) / 10000;
  localparam int     W25_MAX   = (1 << 25) - 1;
  localparam int     DEPTH_MAX = 5592405;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int     N_PHASES  = 12;
  localparam int     PHASE_WORDS = 152;
  localparam int     REPORT_CAP  = 100;

  typedef enum logic {ROW_WORD, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e               kind;
    logic [CFG_IDX_W-1:0]    idx;
    logic signed [31:0]      value;
    logic                    pinned;
    logic signed [23:0]      pinned_out;
  } stim_row_t;

  // Directed rows: extremes straight after reset (held value still zero), then
  // register extremes, then the unused index, then low soften and zero rate.
  localparam stim_row_t DIR_ROWS [25] = '{
    '{ROW_WORD,  '0,             32'sd0,         1'b1, 24'sd0},
    '{ROW_WORD,  '0,             32'sd8388607,   1'b1, 24'sd0},
    '{ROW_WORD,  '0,             -32'sd8388608,  1'b1, 24'sd0},
    '{ROW_WORD,  '0,             -32'sd1,        1'b1, 24'sd0},
    '{ROW_WORD,  '0,             32'sd1,         1'b1, 24'sd0},
    '{ROW_WORD,  '0,             32'sd5592405,   1'b1, 24'sd0},
    '{ROW_WORD,  '0,             -32'sd5592406,  1'b1, 24'sd0},
    '{ROW_WORD,  '0,             32'sd0,         1'b1, 24'sd0},
    '{ROW_WRITE, CFG_RATE_STEP,  32'sd33554431,  1'b0, 24'sd0},
    '{ROW_WRITE, CFG_SOFTEN,     32'sd33554431,  1'b0, 24'sd0},
    '{ROW_WRITE, CFG_DEPTH_STEP, 32'sd5592405,   1'b0, 24'sd0},
    '{ROW_WRITE, CFG_UNUSED,     32'sd33554431,  1'b0, 24'sd0},
    '{ROW_WORD,  '0,             32'sd8388607,   1'b0, 24'sd0},
    '{ROW_WORD,  '0,             -32'sd8388608,  1'b0, 24'sd0},
    '{ROW_WORD,  '0,             32'sd8388607,   1'b0, 24'sd0},
    '{ROW_WORD,  '0,             32'sd1,         1'b0, 24'sd0},
    '{ROW_WORD,  '0,             -32'sd1,        1'b0, 24'sd0},
    '{ROW_WORD,  '0,             32'sd4194304,   1'b0, 24'sd0},
    '{ROW_WORD,  '0,             -32'sd4194304,  1'b0, 24'sd0},
    '{ROW_WRITE, CFG_SOFTEN,     32'sd8388608,   1'b0, 24'sd0},
    '{ROW_WRITE, CFG_RATE_STEP,  32'sd0,         1'b0, 24'sd0},
    '{ROW_WRITE, CFG_DEPTH_STEP, 32'sd0,         1'b0, 24'sd0},
    '{ROW_WORD,  '0,             -32'sd8388608,  1'b0, 24'sd0},
    '{ROW_WORD,  '0,             32'sd8388607,   1'b0, 24'sd0},
    '{ROW_WORD,  '0,             32'sd123456,    1'b0, 24'sd0}
  };

  logic clk;
  logic rst;

  sbrd_sample_if  #(.SAMPLE_WIDTH(24)) sample_bus ();
  sbrd_crushed_if #(.SAMPLE_WIDTH(24)) crushed_bus ();
  sbrd_cfg_if                          cfg_bus ();

  sample_rate_and_bit_depth_reducer_core i_dut (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample_bus),
    .crushed (crushed_bus),
    .cfg     (cfg_bus)
  );

  // Predictor copy of registers and state
  longint unsigned rate_reg, soften_reg, depth_reg;
  longint unsigned rate_smooth, depth_smooth, hold_phase;
  longint          held_word, last_in;
  int              reload_cnt, quant_cnt, clip_cnt, words_checked, fail_count;

  logic signed [23:0] crushed_want_q [$];

  // Pinned expectation for the directed word now on the bus
  bit                 pin_now;
  logic signed [23:0] pin_val;

  // Stall and gap control
  bit word_gaps_on, stall_on;
  int stall_left;

  always #5 clk = ~clk;

  // Product scaled back by 2^24, halves rounded up
  function automatic longint round_q24(input longint v);
    return (v + 64'sd8388608) >>> 24;
  endfunction

  // Crushed sample for one input word; advances the predictor state
  function automatic logic signed [23:0] crush_word(input logic signed [23:0] w);
    longint          xs, p, oldv, y, q;
    longint unsigned rt, sw, stp, mag, k;
    xs = w;
    rt = (rate_reg > ONE_Q) ? ONE_Q : rate_reg;
    sw = (soften_reg > ONE_Q) ? ONE_Q : soften_reg;
    rate_smooth  = (rate_smooth * 999 + (rt << 8)) / 1000;
    depth_smooth = (depth_smooth * 999 + (depth_reg << 8)) / 1000;
    hold_phase   = hold_phase + (rate_smooth >> 8);
    y = held_word;
    // reload only once the phase strictly exceeds one
    if (hold_phase > ONE_Q) begin
      hold_phase = hold_phase - ONE_Q;
      p    = longint'(hold_phase);
      oldv = held_word;
      held_word = round_q24(last_in * p + xs * (ONE_Q - p));
      y = round_q24(oldv * (ONE_Q - longint'(sw)) + held_word * longint'(sw));
      reload_cnt++;
    end
    // quantise away from zero, then scale by one minus the step
    if (depth_smooth > DEPTH_MIN) begin
      stp = depth_smooth >> 8;
      if (stp > 0 && stp < ONE_Q && y != 0) begin
        mag = (y < 0) ? -y : y;
        k   = (mag + stp - 1) / stp;
        q   = round_q24(longint'(k * stp * (ONE_Q - stp)));
        y   = (y < 0) ? -q : q;
        quant_cnt++;
      end
    end
    if (y > S_MAX) begin
      y = S_MAX;
      clip_cnt++;
    end else if (y < S_MIN) begin
      y = S_MIN;
      clip_cnt++;
    end
    last_in    = xs;
    hold_phase = hold_phase & 64'h3FF_FFFF;
    return y[23:0];
  endfunction

  // Track register writes and accepted words
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_bus.index)
          CFG_RATE_STEP:  rate_reg   = cfg_bus.data;
          CFG_SOFTEN:     soften_reg = cfg_bus.data;
          CFG_DEPTH_STEP: depth_reg  = cfg_bus.data[DEPTH_W-1:0];
          default: ;
        endcase
      end
      if (sample_bus.valid && sample_bus.ready) begin
        logic signed [23:0] predicted;
        predicted = crush_word(sample_bus.in_sample);
        crushed_want_q.push_back(pin_now ? pin_val : predicted);
      end
    end
  end

  // Compare each crushed word with the oldest expectation
  always @(posedge clk) begin
    if (!rst && crushed_bus.valid && crushed_bus.ready) begin
      logic signed [23:0] want;
      if (crushed_want_q.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_CAP)
          $error("out_sample: no word expected, actual %0d", crushed_bus.out_sample);
      end else begin
        want = crushed_want_q.pop_front();
        words_checked++;
        if (crushed_bus.out_sample !== want) begin
          fail_count++;
          if (fail_count <= REPORT_CAP)
            $error("out_sample: expected %0d, actual %0d", want, crushed_bus.out_sample);
        end
      end
    end
  end

  // Output stalls in random bursts
  always @(negedge clk) begin
    if (rst || !stall_on) begin
      crushed_bus.ready <= 1'b1;
    end else if (stall_left > 0) begin
      crushed_bus.ready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 3) == 0) begin
      crushed_bus.ready <= 1'b0;
      stall_left = $urandom_range(1, 4) - 1;
    end else begin
      crushed_bus.ready <= 1'b1;
    end
  end

  // Called at a falling edge; returns at the falling edge after the handshake
  task automatic send_word(input logic signed [23:0] w, input bit pin,
                           input logic signed [23:0] pv);
    cfg_bus.valid <= 1'b0;
    if (word_gaps_on && $urandom_range(0, 2) == 0) begin
      sample_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    pin_now = pin;
    pin_val = pv;
    sample_bus.valid     <= 1'b1;
    sample_bus.in_sample <= w;
    @(posedge clk);
    while (!sample_bus.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Register write once every expected word has come back
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    sample_bus.valid <= 1'b0;
    while (crushed_want_q.size() != 0) @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic signed [23:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 24'sh7FFFFF;
      1:       return -24'sh800000;
      2:       return $urandom_range(0, 64) - 32;
      default: return $urandom();
    endcase
  endfunction

  // Stimulus
  initial begin
    logic [CFG_DATA_W-1:0] p_rate, p_soften, p_depth;
    clk = 1'b0;
    rst = 1'b1;
    sample_bus.valid     = 1'b0;
    sample_bus.in_sample = '0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.index        = '0;
    cfg_bus.data         = '0;
    crushed_bus.ready    = 1'b0;
    pin_now = 1'b0;
    pin_val = '0;
    word_gaps_on = 1'b1;
    stall_on     = 1'b1;
    stall_left   = 0;
    rate_reg   = ONE_Q;
    soften_reg = ONE_Q;
    depth_reg  = 0;
    rate_smooth  = 0;
    depth_smooth = 0;
    hold_phase   = 0;
    held_word    = 0;
    last_in      = 0;
    reload_cnt = 0;
    quant_cnt  = 0;
    clip_cnt   = 0;
    words_checked = 0;
    fail_count    = 0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part
    foreach (DIR_ROWS[i]) begin
      if (DIR_ROWS[i].kind == ROW_WRITE)
        write_reg(DIR_ROWS[i].idx, DIR_ROWS[i].value[CFG_DATA_W-1:0]);
      else
        send_word(DIR_ROWS[i].value[23:0], DIR_ROWS[i].pinned, DIR_ROWS[i].pinned_out);
    end

    // Random phases: fixed extremes first, then random settings
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin p_rate = W25_MAX; p_soften = W25_MAX; p_depth = 0;         end
        1: begin p_rate = ONE_Q;   p_soften = 1 << 23; p_depth = DEPTH_MAX; end
        2: begin p_rate = 0;       p_soften = ONE_Q;   p_depth = 8388;      end
        3: begin p_rate = ONE_Q+1; p_soften = ONE_Q+1; p_depth = 8389;      end
        default: begin
          p_rate = ($urandom_range(0, 3) == 0) ? $urandom_range(0, W25_MAX)
                                               : $urandom_range(1 << 22, ONE_Q);
          p_soften = $urandom_range(1 << 23, W25_MAX);
          case ($urandom_range(0, 3))
            0:       p_depth = 0;
            1:       p_depth = {$urandom_range(0, 3), 23'(DEPTH_MAX)};
            default: p_depth = $urandom_range(0, DEPTH_MAX);
          endcase
        end
      endcase
      write_reg(CFG_RATE_STEP, p_rate);
      write_reg(CFG_SOFTEN, p_soften);
      write_reg(CFG_DEPTH_STEP, p_depth);
      // no idling at all in the last phase, and in some earlier ones
      word_gaps_on = (ph != N_PHASES - 1) && (ph % 3 != 2);
      stall_on     = (ph != N_PHASES - 1) && (ph % 4 != 3);
      for (int n = 0; n < PHASE_WORDS; n++)
        send_word(pick_word(), 1'b0, '0);
    end
    sample_bus.valid <= 1'b0;

    // Drain, then wait out anything stray
    while (crushed_want_q.size() != 0) @(negedge clk);
    repeat (70) @(posedge clk);
    $display("Checked %0d crushed words over %0d register settings", words_checked, N_PHASES + 2);
    $display("Seen %0d reloads, %0d quantised words, %0d clipped words",
             reload_cnt, quant_cnt, clip_cnt);
    if (fail_count == 0) begin
      $display("sample_rate_and_bit_depth_reducer_core test passed");
    end else begin
      $display("sample_rate_and_bit_depth_reducer_core test failed");
    end
    $finish;
  end

  // Run limit
  initial begin
    #8_000_000;
    $display("sample_rate_and_bit_depth_reducer_core test failed");
    $finish;
  end

endmodule
